### sv/sbpm_pkg.sv
// Package for the six-button pad multiplexer: codes, reset values and line functions.
`timescale 1ns / 1ps

package sbpm_pkg;

  typedef enum logic {
    OpRead = 1'b0,
    OpTick = 1'b1
  } op_e;

  localparam int unsigned LineW = 7;
  localparam int unsigned ButtonW = 12;
  localparam int unsigned DataW = 8;
  localparam int unsigned TickW = 8;
  localparam int unsigned PhaseW = 2;

  localparam logic [TickW-1:0]  TimeoutReset = 8'd5;
  localparam logic [LineW-1:0]  LinesReset = 7'h7f;
  localparam logic [PhaseW-1:0] PhaseSix = 2'd3;
  localparam logic [PhaseW-1:0] PhaseDirLow = 2'd2;

  // Button positions within the buttons field.
  localparam int unsigned BtnU = 0;
  localparam int unsigned BtnD = 1;
  localparam int unsigned BtnL = 2;
  localparam int unsigned BtnR = 3;
  localparam int unsigned BtnC = 4;
  localparam int unsigned BtnB = 5;
  localparam int unsigned BtnA = 6;
  localparam int unsigned BtnS = 7;
  localparam int unsigned BtnZ = 8;
  localparam int unsigned BtnY = 9;
  localparam int unsigned BtnX = 10;
  localparam int unsigned BtnM = 11;

  // Line levels after select goes high; new_phase is the already advanced phase.
  function automatic logic [LineW-1:0] lines_rise(input logic [ButtonW-1:0] btn,
                                                  input logic [PhaseW-1:0] new_phase);
    logic [3:0] dir;
    if (new_phase == PhaseSix) begin
      dir = ~{btn[BtnM], btn[BtnX], btn[BtnY], btn[BtnZ]};
    end else begin
      dir = ~{btn[BtnR], btn[BtnL], btn[BtnD], btn[BtnU]};
    end
    return {1'b1, ~btn[BtnC], ~btn[BtnB], dir};
  endfunction

  // Line levels after select goes low.
  function automatic logic [LineW-1:0] lines_fall(input logic [ButtonW-1:0] btn,
                                                  input logic [PhaseW-1:0] phase);
    logic [3:0] dir;
    if (phase == PhaseDirLow) begin
      dir = 4'b0000;
    end else if (phase == PhaseSix) begin
      dir = 4'b1111;
    end else begin
      dir = {2'b00, ~btn[BtnD], ~btn[BtnU]};
    end
    return {1'b0, ~btn[BtnS], ~btn[BtnA], dir};
  endfunction

endpackage

### sv/six_button_pad_multiplexer_core.sv
// Top level of the six-button pad multiplexer: port B read and tick handling.
`timescale 1ns / 1ps

// Takes one item per clock cycle. A port B read returns, in the cycle after it is
// accepted, the line byte that was in place before the read; a tick updates the
// idle count, clearing it and the phase on a timeout, and returns nothing. The only
// stall comes from the single output register: a new item is taken whenever that
// register is empty or its result is taken in the same cycle. The timeout register
// may be written at any time the block is idle and takes effect on the next tick.
module six_button_pad_multiplexer_core import sbpm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TickW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic               select_request_i,
  input  logic [ButtonW-1:0] buttons_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DataW-1:0]   read_data_o
);

  logic [TickW-1:0]  timeout_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [TickW-1:0]  idle_q, idle_d;
  logic [LineW-1:0]  line_q, line_d;
  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  read_data_q;
  logic              in_acc;
  logic              is_read;
  logic [PhaseW-1:0] phase_inc;
  logic [TickW-1:0]  idle_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_read    = (op_e'(opcode_i) == OpRead);
  assign phase_inc  = phase_q + 2'd1;
  assign idle_inc   = idle_q + 8'd1;

  always_comb begin
    phase_d     = phase_q;
    idle_d      = idle_q;
    line_d      = line_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_acc) begin
      if (is_read) begin
        out_valid_d = 1'b1;
        if (select_request_i && !line_q[LineW-1]) begin
          phase_d = phase_inc;
          idle_d  = '0;
          line_d  = lines_rise(buttons_i, phase_inc);
        end else if (!select_request_i && line_q[LineW-1]) begin
          line_d = lines_fall(buttons_i, phase_q);
        end
      end else begin
        // The count wraps modulo 256, so a timeout of zero matches on the wrap.
        if (idle_inc == timeout_q) begin
          idle_d  = '0;
          phase_d = '0;
        end else begin
          idle_d = idle_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TimeoutReset;
      phase_q     <= '0;
      idle_q      <= '0;
      line_q      <= LinesReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      phase_q     <= phase_d;
      idle_q      <= idle_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_read) begin
      read_data_q <= {1'b1, line_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_read) |=> out_valid_o)
    else $error("accepted read did not produce a result");

  a_select_tracks_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_read) |=> (line_q[LineW-1] == $past(select_request_i)))
    else $error("select level does not follow the last read");

  a_rise_advances_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_read && select_request_i && !line_q[LineW-1])
      |=> (phase_q == $past(phase_inc)) && (idle_q == '0))
    else $error("rising select did not advance the phase");

  a_tick_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_read && !out_valid_q) |=> !out_valid_o)
    else $error("tick produced a result");

endmodule
